// ----- rtl/scratchpad_crc_temp_decode_unit_defines.svh -----
// Assertion macros shared by the decode unit
`ifndef SCRATCHPAD_CRC_TEMP_DECODE_UNIT_DEFINES_SVH
`define SCRATCHPAD_CRC_TEMP_DECODE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SCDEC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scdec: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define SCDEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scdec: next-cycle check failed");

`endif

// ----- rtl/scdec_pkg.sv -----
package scdec_pkg;

   // Field widths
   localparam int DATA_W  = 8;
   localparam int IDX_W   = 4;
   localparam int TEMP_W  = 19;
   localparam int RSP_W   = 32;

   // Bytes covered by the CRC before the check byte
   localparam int CRC_SPAN_DEFAULT = 8;

   // Reflected 1-Wire CRC-8 polynomial
   localparam logic [DATA_W-1:0] CRC_POLY = 8'h8C;

   // Temperature reported on a CRC mismatch
   localparam logic signed [TEMP_W-1:0] CRC_ERR_VALUE = -19'sd100;

   // One byte of the CRC, LSB first
   function automatic logic [DATA_W-1:0] crc_byte_update(input logic [DATA_W-1:0] crc_in,
                                                       input logic [DATA_W-1:0] data_in);
      logic [DATA_W-1:0] crc;
      logic [DATA_W-1:0] b;
      logic              mix;
      crc = crc_in;
      b   = data_in;
      for (int k = 0; k < DATA_W; k++) begin
         mix = crc[0] ^ b[0];
         crc = crc >> 1;
         if (mix) begin
            crc = crc ^ CRC_POLY;
         end
         b = b >> 1;
      end
      return crc;
   endfunction

   // sign * ((|raw| * 25) >> 2)
   function automatic logic [TEMP_W-1:0] decode_temp(input logic [DATA_W-1:0] lo,
                                                    input logic [DATA_W-1:0] hi);
      logic [15:0] raw;
      logic        neg;
      logic [16:0] mag;
      logic [21:0] prod;
      logic [19:0] val;
      raw  = {hi, lo};
      neg  = raw[15];
      // invert in 16 bits, then widen
      mag  = neg ? ({1'b0, ~raw} + 17'd1) : {1'b0, raw};
      prod = {1'b0, mag, 4'b0} + {2'b0, mag, 3'b0} + {5'b0, mag};
      val  = prod[21:2];
      if (neg) begin
         val = 20'd0 - val;
      end
      return val[TEMP_W-1:0];
   endfunction

endpackage

// ----- rtl/scratchpad_crc_temp_decode_unit.sv -----
// Scratchpad CRC check and temperature decode.
// req channel: one scratchpad byte per transfer, req_tuser flags byte 0 of a
// new scratchpad and restarts the CRC and byte count. The CRC-8 runs over the
// first CRC_SPAN bytes; bytes 0 and 1 are kept as the raw temperature.
// rsp channel: one transfer per scratchpad, produced by the check byte that
// follows the CRC span. It carries the temperature in hundredths of a degree
// (or -100 on mismatch), the computed CRC and the match flag.
// Path: a byte taken on req enters the input register; a check byte then
// loads the result register, which drives rsp_tvalid.
// Throughput: one byte per cycle while no check byte waits (see Stalls), set by
// the single input register feeding a byte-wide CRC update and the result register.
// Stalls: while rsp holds an untaken result, bytes that make no result keep
// flowing; the next check byte waits in the input register and req_tready
// drops until rsp_tready frees the result register.
// Reset clears the CRC, byte count and both valid flags; the first byte
// after reset is byte 0 even without req_tuser.
`include "scratchpad_crc_temp_decode_unit_defines.svh"

module scratchpad_crc_temp_decode_unit #(
   parameter int CRC_SPAN = scdec_pkg::CRC_SPAN_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // req_tdata: [7:0] data_byte
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [scdec_pkg::DATA_W-1:0]  req_tdata,
   // req_tuser: [0] first_byte
   input  logic                          req_tuser,
   // rsp_tdata: [18:0] temp_centi, [26:19] computed_crc, [31:27] zero
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [scdec_pkg::RSP_W-1:0]   rsp_tdata,
   // rsp_tuser: [0] crc_ok
   output logic                          rsp_tuser
);

   localparam logic [scdec_pkg::IDX_W-1:0] SPAN_IDX = scdec_pkg::IDX_W'(CRC_SPAN);

   // Input register
   logic                         in_valid_ff, in_valid_in;
   logic [scdec_pkg::DATA_W-1:0] in_byte_ff;
   logic                         in_first_ff;

   // Frame state
   logic [scdec_pkg::DATA_W-1:0] crc_ff, crc_in;
   logic [scdec_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic [scdec_pkg::DATA_W-1:0] temp_low_ff;
   logic [scdec_pkg::DATA_W-1:0] temp_high_ff;

   // Result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [scdec_pkg::TEMP_W-1:0] rsp_temp_ff;
   logic [scdec_pkg::DATA_W-1:0] rsp_crc_ff;
   logic                         rsp_ok_ff;

   logic [scdec_pkg::DATA_W-1:0] crc_eff;
   logic [scdec_pkg::IDX_W-1:0]  idx_eff;
   logic                         is_check;
   logic                         advance;
   logic                         crc_match;

   // Effective frame position for the byte in the input register
   assign crc_eff   = in_first_ff ? '0 : crc_ff;
   assign idx_eff   = in_first_ff ? '0 : idx_ff;
   assign is_check  = (idx_eff >= SPAN_IDX);
   assign crc_match = (crc_eff == in_byte_ff);

   // Data bytes always move on; the check byte needs a free result slot
   assign advance    = in_valid_ff && (!is_check || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Next state
   always_comb begin
      in_valid_in  = req_tvalid ? 1'b1 : (in_valid_ff && !advance);
      crc_in       = crc_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (advance) begin
         if (is_check) begin
            crc_in       = '0;
            idx_in       = '0;
            rsp_valid_in = 1'b1;
         end else begin
            crc_in = scdec_pkg::crc_byte_update(crc_eff, in_byte_ff);
            idx_in = idx_eff + 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         crc_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         crc_ff       <= crc_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_first_ff <= req_tuser;
      end
      if (advance && !is_check) begin
         if (idx_eff == '0) begin
            temp_low_ff <= in_byte_ff;
         end
         if (idx_eff == scdec_pkg::IDX_W'(1)) begin
            temp_high_ff <= in_byte_ff;
         end
      end
      if (advance && is_check) begin
         rsp_temp_ff <= crc_match ? scdec_pkg::decode_temp(temp_low_ff, temp_high_ff)
                                  : scdec_pkg::CRC_ERR_VALUE;
         rsp_crc_ff  <= crc_eff;
         rsp_ok_ff   <= crc_match;
      end
   end

   // Result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {{(scdec_pkg::RSP_W - scdec_pkg::TEMP_W - scdec_pkg::DATA_W){1'b0}},
                        rsp_crc_ff, rsp_temp_ff};

   // Checks
   `SCDEC_ASSERT_NEXT(a_in_hold, clock, reset,
      in_valid_ff && !advance, in_valid_ff && $stable(in_byte_ff))
   `SCDEC_ASSERT_NOW(a_rsp_from_check, clock, reset,
      $rose(rsp_valid_ff), $past(advance && is_check))
   `SCDEC_ASSERT_NEXT(a_check_restarts, clock, reset,
      advance && is_check, rsp_valid_ff && idx_ff == '0 && crc_ff == '0)

endmodule

// ----- dv/scdec_checker.sv -----
`timescale 1ns / 1ps

package scratchpad_tb_pkg;

   // One decoded scratchpad as it shows on the rsp channel
   typedef struct packed {
      logic signed [scdec_pkg::TEMP_W-1:0] temp_centi;
      logic                                crc_ok;
      logic [scdec_pkg::DATA_W-1:0]        computed_crc;
   } scratch_result_t;

   // Reflected 1-Wire CRC-8 over one byte, LSB first
   function automatic logic [7:0] crc8_onewire(input logic [7:0] crc_in,
                                               input logic [7:0] data);
      logic [7:0] acc;
      logic [7:0] d;
      acc = crc_in;
      d   = data;
      for (int k = 0; k < 8; k++) begin
         if (acc[0] ^ d[0]) begin
            acc = (acc >> 1) ^ scdec_pkg::CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
         d = d >> 1;
      end
      return acc;
   endfunction

endpackage

// Watches both channels, tracks the scratchpad framing and checks each result
module scdec_checker #(
   parameter int SPAN = scdec_pkg::CRC_SPAN_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [scdec_pkg::DATA_W-1:0]  req_tdata,
   input  logic                          req_tuser,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [scdec_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                          rsp_tuser,
   output int                            mismatch_count,
   output int                            pending_count
);
   import scratchpad_tb_pkg::*;

   localparam int TW = scdec_pkg::TEMP_W;
   localparam int DW = scdec_pkg::DATA_W;

   // Predicted framing state
   logic [7:0] crc_run  = '0;
   logic [3:0] next_idx = '0;
   logic [7:0] raw_lo   = '0;
   logic [7:0] raw_hi   = '0;

   scratch_result_t decoded_q[$];
   int errors = 0;

   assign mismatch_count = errors;
   assign pending_count  = decoded_q.size();

   // Signed 16-bit raw reading to hundredths, magnitude truncated
   function automatic logic signed [TW-1:0] centi_from_raw(input logic [15:0] raw);
      int mag;
      int val;
      mag = raw[15] ? (32'h10000 - int'(raw)) : int'(raw);
      val = (mag * 25) >>> 2;
      if (raw[15]) begin
         val = -val;
      end
      return val[TW-1:0];
   endfunction

   always @(posedge clock) begin : watch
      scratch_result_t want;
      logic [3:0]      idx;
      if (reset) begin
         crc_run  = '0;
         next_idx = '0;
         decoded_q.delete();
      end else begin
         // result transfer: compare with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_q.size() == 0) begin
               $display("%0t: unexpected result tdata %h tuser %b",
                        $time, rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               want = decoded_q.pop_front();
               if (rsp_tdata[TW-1:0] !== want.temp_centi) begin
                  $display("%0t: temp_centi expected %0d actual %0d", $time,
                           want.temp_centi, $signed(rsp_tdata[TW-1:0]));
                  errors++;
               end
               if (rsp_tdata[TW+DW-1:TW] !== want.computed_crc) begin
                  $display("%0t: computed_crc expected %h actual %h", $time,
                           want.computed_crc, rsp_tdata[TW+DW-1:TW]);
                  errors++;
               end
               if (rsp_tdata[scdec_pkg::RSP_W-1:TW+DW] !== '0) begin
                  $display("%0t: tdata padding expected 0 actual %h", $time,
                           rsp_tdata[scdec_pkg::RSP_W-1:TW+DW]);
                  errors++;
               end
               if (rsp_tuser !== want.crc_ok) begin
                  $display("%0t: crc_ok expected %b actual %b", $time,
                           want.crc_ok, rsp_tuser);
                  errors++;
               end
            end
         end

         // byte transfer: advance the CRC, keep bytes 0 and 1
         if (req_tvalid && req_tready) begin
            if (req_tuser) begin
               crc_run  = '0;
               next_idx = '0;
            end
            idx = next_idx;
            if (idx < SPAN) begin
               if (idx == 0) begin
                  raw_lo = req_tdata;
               end else if (idx == 1) begin
                  raw_hi = req_tdata;
               end
               crc_run  = crc8_onewire(crc_run, req_tdata);
               next_idx = idx + 4'd1;
            end else begin
               // check byte: one result per scratchpad
               want.computed_crc = crc_run;
               want.crc_ok       = (crc_run == req_tdata);
               want.temp_centi   = want.crc_ok ? centi_from_raw({raw_hi, raw_lo})
                                               : scdec_pkg::CRC_ERR_VALUE;
               decoded_q.push_back(want);
               crc_run  = '0;
               next_idx = '0;
            end
         end
      end
   end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   localparam int SPAN         = scdec_pkg::CRC_SPAN_DEFAULT;
   localparam int RANDOM_BYTES = 950;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;

   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [scdec_pkg::DATA_W-1:0] req_tdata  = '0;
   logic                         req_tuser  = 1'b0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [scdec_pkg::RSP_W-1:0]  rsp_tdata;
   logic                         rsp_tuser;

   int mismatch_count;
   int pending_count;

   int idle_pct    = 0;
   int stall_pct   = 0;
   bit hold_arm    = 1'b0;
   bit hold_done   = 1'b0;
   int hold_left   = 0;
   int sent        = 0;
   int cycle_count = 0;
   bit restart_due = 1'b0;

   scratchpad_crc_temp_decode_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   scdec_checker #(.SPAN(SPAN)) crc_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always #5 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold-off once armed
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_arm && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // One byte transfer, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] value, input logic first);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   // Filler bytes lean toward the extremes
   function automatic logic [7:0] pick_pad();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [15:0] pick_raw();
      if ($urandom_range(3) != 0) begin
         return 16'($urandom_range(16'hFFFF));
      end
      case ($urandom_range(5))
         0:       return 16'h0000;
         1:       return 16'h7FFF;
         2:       return 16'h8000;
         3:       return 16'hFFFF;
         4:       return 16'h0001;
         default: return 16'hFFFE;
      endcase
   endfunction

   // Scratchpad of SPAN bytes plus the check byte; keep cuts it short.
   // A cut frame forces the start flag on the next one.
   task automatic send_frame(input logic [15:0] raw, input logic first, input bit good,
                             input int keep, input int pad);
      logic [7:0] frame [0:SPAN];
      logic [7:0] crc;
      crc = 8'h00;
      for (int i = 0; i < SPAN; i++) begin
         frame[i] = (i == 0) ? raw[7:0] :
                    (i == 1) ? raw[15:8] :
                    (pad < 0) ? pick_pad() : pad[7:0];
         crc = scratchpad_tb_pkg::crc8_onewire(crc, frame[i]);
      end
      frame[SPAN] = good ? crc : crc ^ 8'($urandom_range(1, 255));
      for (int i = 0; i < keep; i++) begin
         send_byte(frame[i], (i == 0) && (first || restart_due));
      end
      restart_due = (keep <= SPAN);
   endtask

   initial begin : stimulus
      int base;
      int phase;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: no flag after reset, most negative reading
      send_frame(16'h8000, 1'b0, 1'b1, SPAN + 1, 8'h00);
      // partial frame dropped by a restart, then a bad CRC
      send_frame(16'h7FFF, 1'b1, 1'b1, 2, 8'hFF);
      send_frame(16'hFFFF, 1'b1, 1'b0, SPAN + 1, 8'hFF);
      // right after a check byte, no flag
      send_frame(16'h0191, 1'b0, 1'b1, SPAN + 1, -1);

      // random scratchpads over the idling phases
      hold_arm <= 1'b1;
      base = sent;
      while (sent - base < RANDOM_BYTES) begin
         phase = (sent - base) * 4 / RANDOM_BYTES;
         case (phase)
            0: begin
               idle_pct  = 0;
               stall_pct <= 0;
            end
            1: begin
               idle_pct  = 73;
               stall_pct <= 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct <= 73;
            end
            default: begin
               idle_pct  = 17;
               stall_pct <= 17;
            end
         endcase
         send_frame(pick_raw(), 1'($urandom_range(1)), $urandom_range(99) < 80,
                    ($urandom_range(99) < 12) ? $urandom_range(1, SPAN) : SPAN + 1, -1);
      end
      req_tvalid <= 1'b0;
      stall_pct  <= 0;

      // drain, then let the pipeline settle
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
